// ===== rtl/ifnb_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and the four-way average for the in-place blur
package ifnb_pkg;

    // column fields in the internal queue cover the largest supported row store
    localparam int COL_W = 12;
    localparam int ROW_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW    = 2'd2;

    localparam logic [9:0]       WIDTH_RESET     = 10'd512;
    localparam logic [ROW_W-1:0] HEIGHT_RESET    = 12'd512;
    localparam logic [ROW_W-1:0] FIRST_ROW_RESET = 12'd16;
    localparam logic [ROW_W-1:0] MIN_HEIGHT      = 12'd3;
    localparam logic [ROW_W-1:0] MIN_FIRST_ROW   = 12'd1;
    localparam int               MIN_WIDTH       = 2;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [8:0]       column;
        logic [ROW_W-1:0] row_index;
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic             last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // one classified pixel on its way from the front to the back
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] col_right;
        logic [COL_W-1:0] col_left;
        logic [ROW_W-1:0] row;
        t_pixel           pix;
        logic             blur;
        logic             has_first;
        logic             last_row;
    } t_entry;

    function automatic t_pixel blend4(input t_pixel a, input t_pixel b,
                                      input t_pixel c, input t_pixel d);
        logic [9:0] s_r;
        logic [9:0] s_g;
        logic [9:0] s_b;
        t_pixel     res;
        s_r = 10'(a.red) + 10'(b.red) + 10'(c.red) + 10'(d.red);
        s_g = 10'(a.green) + 10'(b.green) + 10'(c.green) + 10'(d.green);
        s_b = 10'(a.blue) + 10'(b.blue) + 10'(c.blue) + 10'(d.blue);
        res.red   = s_r[9:2];
        res.green = s_g[9:2];
        res.blue  = s_b[9:2];
        return res;
    endfunction

endpackage

// ===== rtl/ifnb_queue.sv =====
`timescale 1ns / 1ps
// small register queue taking up to two entries and giving one per cycle while i_rd_en is high
module ifnb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en0,
    input  logic                       i_wr_en1,
    input  logic [WIDTH-1:0]           i_wr_data0,
    input  logic [WIDTH-1:0]           i_wr_data1,
    input  logic                       i_rd_en,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic [$clog2(DEPTH):0]     o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic [AW:0]      n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_wr_en0) + AW'(i_wr_en1);
        n_rd_ptr = r_rd_ptr + AW'(i_rd_en);
        n_count  = r_count + (AW+1)'(i_wr_en0) + (AW+1)'(i_wr_en1) - (AW+1)'(i_rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en0) begin
            r_mem[r_wr_ptr] <= i_wr_data0;
        end
        if (i_wr_en1) begin
            r_mem[r_wr_ptr + AW'(1)] <= i_wr_data1;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_count   = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue holds more entries than it has");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> r_count != '0)
        else $error("queue read while empty");

    a_second_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en1 |-> i_wr_en0)
        else $error("second write slot used without the first");

endmodule

// ===== rtl/ifnb_front.sv =====
`timescale 1ns / 1ps
// front part: configuration registers, raster counters and pixel classification
module ifnb_front #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ifnb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ifnb_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ifnb_pkg::t_in_item                   i_in_data,
    input  logic                                 i_q_room,
    output logic                                 o_push,
    output ifnb_pkg::t_entry                     o_entry
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int XW = (WB > 10) ? WB : 10;
    localparam int RW = ifnb_pkg::ROW_W;
    localparam int KW = ifnb_pkg::COL_W;

    logic [9:0]    r_frame_width;
    logic [RW-1:0] r_frame_height;
    logic [RW-1:0] r_first_row;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    logic [XW-1:0] fw_x;
    logic [XW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [RW-1:0] fr_eff;
    logic [XW:0]   col_x;
    logic [RW:0]   row_x;
    logic [RW:0]   row_p1;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = i_q_room;
    assign o_push      = i_in_valid && i_q_room;

    always_comb begin
        fw_x = XW'(r_frame_width);
        if (fw_x < XW'(ifnb_pkg::MIN_WIDTH)) begin
            w_eff = XW'(ifnb_pkg::MIN_WIDTH);
        end else if (fw_x > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = fw_x;
        end
        h_eff  = (r_frame_height < ifnb_pkg::MIN_HEIGHT) ? ifnb_pkg::MIN_HEIGHT
                                                         : r_frame_height;
        fr_eff = (r_first_row < ifnb_pkg::MIN_FIRST_ROW) ? ifnb_pkg::MIN_FIRST_ROW
                                                         : r_first_row;
        col_x  = (XW+1)'(r_col);
        row_x  = (RW+1)'(r_row);
        row_p1 = row_x + (RW+1)'(1);

        o_entry.col       = KW'(r_col);
        o_entry.col_right = KW'(col_x + (XW+1)'(1));
        o_entry.col_left  = KW'(w_eff - XW'(1));
        o_entry.row       = r_row;
        o_entry.pix.red   = i_in_data.red_in;
        o_entry.pix.green = i_in_data.green_in;
        o_entry.pix.blue  = i_in_data.blue_in;
        o_entry.has_first = (r_row != '0);
        o_entry.last_row  = (row_p1 == (RW+1)'(h_eff));
        // row above is at or past the first blurred row, not the last row,
        // and the pixel has a right neighbour
        o_entry.blur      = (row_x >= (RW+1)'(fr_eff) + (RW+1)'(1))
                         && (row_p1 <= (RW+1)'(h_eff))
                         && (col_x + (XW+1)'(2) <= (XW+1)'(w_eff));

        if (col_x + (XW+1)'(1) >= (XW+1)'(w_eff)) begin
            n_col = '0;
            n_row = (row_p1 >= (RW+1)'(h_eff)) ? '0 : RW'(row_p1);
        end else begin
            n_col = CW'(col_x + (XW+1)'(1));
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= ifnb_pkg::WIDTH_RESET;
            r_frame_height <= ifnb_pkg::HEIGHT_RESET;
            r_first_row    <= ifnb_pkg::FIRST_ROW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ifnb_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[9:0];
                end
                ifnb_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                ifnb_pkg::CFG_FIRST_ROW: begin
                    r_first_row <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= CW'(MAX_WIDTH - 1))
        else $error("column counter beyond the row store");

    a_last_row_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.last_row |-> o_entry.has_first)
        else $error("last row pixel without a pending upper row pixel");

    a_blur_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_entry.blur |-> o_entry.has_first)
        else $error("blur requested on the top row");

endmodule

// ===== rtl/ifnb_back.sv =====
`timescale 1ns / 1ps
// back part: row stores, blur datapath with write forwarding and result queue
module ifnb_back #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ifnb_pkg::t_entry      i_q_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ifnb_pkg::t_out_item   o_out_data
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RQ_DEPTH = 4;
    localparam int RQ_CW    = $clog2(RQ_DEPTH) + 1;
    localparam int OW       = $bits(ifnb_pkg::t_out_item);

    ifnb_pkg::t_pixel r_in_mem  [MAX_WIDTH];
    ifnb_pkg::t_pixel r_out_mem [MAX_WIDTH];

    logic             r_s2_valid;
    ifnb_pkg::t_entry r_s2;
    ifnb_pkg::t_pixel r_rd_in_c;
    ifnb_pkg::t_pixel r_rd_in_r;
    ifnb_pkg::t_pixel r_rd_out_c;
    ifnb_pkg::t_pixel r_rd_out_l;
    logic [CW-1:0]    r_fw_in_addr;
    ifnb_pkg::t_pixel r_fw_in_pix;
    logic [CW-1:0]    r_fw_out_addr;
    ifnb_pkg::t_pixel r_fw_out_pix;
    ifnb_pkg::t_pixel r_left;

    logic [CW-1:0]       s2_col;
    logic [CW-1:0]       s2_col_r;
    logic [CW-1:0]       s2_col_l;
    ifnb_pkg::t_pixel    in_c;
    ifnb_pkg::t_pixel    in_r;
    ifnb_pkg::t_pixel    up;
    ifnb_pkg::t_pixel    out_l;
    ifnb_pkg::t_pixel    left;
    ifnb_pkg::t_pixel    val;
    logic [1:0]          s2_n;
    logic                s2_fire;
    ifnb_pkg::t_out_item res0;
    ifnb_pkg::t_out_item res1;
    logic                rq_wr0;
    logic                rq_wr1;
    logic                rq_rd;
    logic [OW-1:0]       rq_data;
    logic [RQ_CW-1:0]    rq_count;

    always_comb begin
        s2_col   = r_s2.col[CW-1:0];
        s2_col_r = r_s2.col_right[CW-1:0];
        s2_col_l = r_s2.col_left[CW-1:0];
        // the previous pixel's writes land on the edge the reads were taken
        in_c  = (r_fw_in_addr == s2_col) ? r_fw_in_pix : r_rd_in_c;
        in_r  = (r_fw_in_addr == s2_col_r) ? r_fw_in_pix : r_rd_in_r;
        up    = (r_fw_out_addr == s2_col) ? r_fw_out_pix : r_rd_out_c;
        out_l = (r_fw_out_addr == s2_col_l) ? r_fw_out_pix : r_rd_out_l;
        // column 0 takes the last pixel of the row above as its left neighbour
        left  = (s2_col == '0) ? out_l : r_left;
        val   = r_s2.blur ? ifnb_pkg::blend4(in_r, left, r_s2.pix, up) : in_c;

        s2_n    = {1'b0, r_s2.has_first} + {1'b0, r_s2.last_row};
        s2_fire = r_s2_valid && (rq_count + RQ_CW'(s2_n) <= RQ_CW'(RQ_DEPTH));
        o_pop   = i_q_valid && (!r_s2_valid || s2_fire);

        res0.column      = r_s2.col[8:0];
        res0.row_index   = r_s2.row - ifnb_pkg::ROW_W'(1);
        res0.red_out     = val.red;
        res0.green_out   = val.green;
        res0.blue_out    = val.blue;
        res0.last_of_run = !r_s2.last_row;

        res1.column      = r_s2.col[8:0];
        res1.row_index   = r_s2.row;
        res1.red_out     = r_s2.pix.red;
        res1.green_out   = r_s2.pix.green;
        res1.blue_out    = r_s2.pix.blue;
        res1.last_of_run = 1'b1;

        rq_wr0 = s2_fire && r_s2.has_first;
        rq_wr1 = s2_fire && r_s2.last_row;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_in_c <= r_in_mem[i_q_entry.col[CW-1:0]];
            r_rd_in_r <= r_in_mem[i_q_entry.col_right[CW-1:0]];
        end
        if (s2_fire) begin
            r_in_mem[s2_col] <= r_s2.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_out_c <= r_out_mem[i_q_entry.col[CW-1:0]];
            r_rd_out_l <= r_out_mem[i_q_entry.col_left[CW-1:0]];
        end
        if (s2_fire && r_s2.has_first) begin
            r_out_mem[s2_col] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            if (o_pop) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_fire && r_s2.has_first) begin
                r_left <= val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s2 <= i_q_entry;
        end
        if (s2_fire) begin
            r_fw_in_addr <= s2_col;
            r_fw_in_pix  <= r_s2.pix;
            if (r_s2.has_first) begin
                r_fw_out_addr <= s2_col;
                r_fw_out_pix  <= val;
            end
        end
    end

    ifnb_queue #(
        .WIDTH (OW),
        .DEPTH (RQ_DEPTH)
    ) u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en0   (rq_wr0),
        .i_wr_en1   (rq_wr1),
        .i_wr_data0 (res0),
        .i_wr_data1 (res1),
        .i_rd_en    (rq_rd),
        .o_rd_data  (rq_data),
        .o_count    (rq_count)
    );

    assign o_out_valid = (rq_count != '0);
    assign rq_rd       = o_out_valid && i_out_ready;
    assign o_out_data  = ifnb_pkg::t_out_item'(rq_data);

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2.last_row |-> r_s2.has_first)
        else $error("second result without the first");

    a_blur_has_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2.blur |-> r_s2.col < r_s2.col_left)
        else $error("blurred pixel in the last column");

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s2_valid)
        else $error("popped pixel lost before the datapath stage");

endmodule

// ===== rtl/inplace_four_neighbour_blur.sv =====
`timescale 1ns / 1ps
// top level of the in-place four-neighbour blur on a raster-order rgb stream
//
// channels: pixel input (i_in_valid / o_in_ready / i_in_data), result output
// (o_out_valid / i_out_ready / o_out_data) and a register write port
// (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data), always ready.
// registers: 0 frame width, 1 frame height, 2 first blurred row; write them
// only while no pixel is in flight.
// each pixel of row r >= 1 releases the pixel above it, blurred or passed
// through, tagged with its column and row; pixels of the last row release
// themselves as a second result. row 0 releases nothing.
// throughput: one pixel per clock while the output is taken, set by the
// row stores (two reads and a write each) and the blend stage; last-row
// pixels give two results each, so there the output port limits the rate.
// a pixel passes the entry queue, the store read and the blend into the
// result queue before its result can be taken.
// reset clears counters, registers to their defaults and both queues; the row
// stores need no clearing. a stalled receiver fills the result queue, then the
// blend stage and the entry queue, and only then drops o_in_ready.
module inplace_four_neighbour_blur #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ifnb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ifnb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ifnb_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ifnb_pkg::t_out_item               o_out_data
);

    localparam int EQ_DEPTH = 2;
    localparam int EQ_CW    = $clog2(EQ_DEPTH) + 1;
    localparam int EW       = $bits(ifnb_pkg::t_entry);

    logic             q_room;
    logic             push;
    ifnb_pkg::t_entry entry;
    logic             pop;
    logic [EW-1:0]    eq_data;
    logic [EQ_CW-1:0] eq_count;
    logic             eq_valid;

    assign q_room   = (eq_count < EQ_CW'(EQ_DEPTH));
    assign eq_valid = (eq_count != '0);

    ifnb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_room    (q_room),
        .o_push      (push),
        .o_entry     (entry)
    );

    ifnb_queue #(
        .WIDTH (EW),
        .DEPTH (EQ_DEPTH)
    ) u_entry_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en0   (push),
        .i_wr_en1   (1'b0),
        .i_wr_data0 (entry),
        .i_wr_data1 ({EW{1'b0}}),
        .i_rd_en    (pop),
        .o_rd_data  (eq_data),
        .o_count    (eq_count)
    );

    ifnb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (eq_valid),
        .i_q_entry   (ifnb_pkg::t_entry'(eq_data)),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/inplace_four_neighbour_blur_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the in-place four-neighbour blur, scored against a behavioural pass
module inplace_four_neighbour_blur_tb;

    localparam int MAX_W        = 512;
    localparam int DRAIN_CYCLES = 6;
    localparam int CFG_IW       = ifnb_pkg::CFG_IDX_W;
    localparam int CFG_DW       = ifnb_pkg::CFG_DATA_W;
    localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IW-1:0]     i_cfg_index = '0;
    logic [CFG_DW-1:0]     i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    ifnb_pkg::t_in_item    i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    ifnb_pkg::t_out_item   o_out_data;

    // behavioural copy of the block state
    ifnb_pkg::t_pixel orig_line [MAX_W];
    ifnb_pkg::t_pixel done_line [MAX_W];
    ifnb_pkg::t_pixel prev_done  = '0;
    int unsigned col_pos    = 0;
    int unsigned row_pos    = 0;
    logic [9:0]  reg_width  = ifnb_pkg::WIDTH_RESET;
    logic [11:0] reg_height = ifnb_pkg::HEIGHT_RESET;
    logic [11:0] reg_first  = ifnb_pkg::FIRST_ROW_RESET;

    ifnb_pkg::t_out_item awaited_pixels [$];
    int unsigned in_idle_rate  = 8;
    int unsigned out_idle_rate = 8;
    int          err_cnt       = 0;
    int unsigned pix_sent      = 0;
    int unsigned res_seen      = 0;
    int unsigned settings_used = 0;

    inplace_four_neighbour_blur #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("inplace_four_neighbour_blur_tb: done, errors");
        $finish;
    end

    function automatic int unsigned eff_width();
        if (reg_width < ifnb_pkg::MIN_WIDTH) return ifnb_pkg::MIN_WIDTH;
        if (reg_width > MAX_W) return MAX_W;
        return 32'(reg_width);
    endfunction

    function automatic int unsigned eff_height();
        return 32'((reg_height < ifnb_pkg::MIN_HEIGHT) ? ifnb_pkg::MIN_HEIGHT : reg_height);
    endfunction

    function automatic int unsigned eff_first();
        return 32'((reg_first < ifnb_pkg::MIN_FIRST_ROW) ? ifnb_pkg::MIN_FIRST_ROW : reg_first);
    endfunction

    function automatic logic [7:0] quarter_sum(logic [7:0] a, logic [7:0] b,
                                               logic [7:0] c, logic [7:0] d);
        logic [9:0] total;
        total = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return total[9:2];
    endfunction

    // advance the model by one pixel and queue the results it releases
    task automatic emit_expected_pixels(input ifnb_pkg::t_in_item px);
        int unsigned w, h, fr, c, r;
        ifnb_pkg::t_pixel    cur, val, right, left, up;
        ifnb_pkg::t_out_item above, self;
        w = eff_width();
        h = eff_height();
        fr = eff_first();
        c = col_pos;
        r = row_pos;
        cur.red = px.red_in;
        cur.green = px.green_in;
        cur.blue = px.blue_in;
        if (r >= 1) begin
            if (r - 1 >= fr && r + 1 <= h && c + 2 <= w) begin
                right = orig_line[c + 1];
                // column 0 takes the finished end of the row above as its left side
                left = (c == 0) ? done_line[w - 1] : prev_done;
                up = done_line[c];
                val.red = quarter_sum(right.red, left.red, cur.red, up.red);
                val.green = quarter_sum(right.green, left.green, cur.green, up.green);
                val.blue = quarter_sum(right.blue, left.blue, cur.blue, up.blue);
            end else begin
                val = orig_line[c];
            end
            done_line[c] = val;
            prev_done = val;
            above.column = 9'(c);
            above.row_index = 12'(r - 1);
            above.red_out = val.red;
            above.green_out = val.green;
            above.blue_out = val.blue;
            above.last_of_run = (r + 1 != h);
            awaited_pixels.push_back(above);
        end
        orig_line[c] = cur;
        if (r + 1 == h) begin
            self.column = 9'(c);
            self.row_index = 12'(r);
            self.red_out = cur.red;
            self.green_out = cur.green;
            self.blue_out = cur.blue;
            self.last_of_run = 1'b1;
            awaited_pixels.push_back(self);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic ifnb_pkg::t_in_item rand_pixel();
        ifnb_pkg::t_in_item px;
        px.red_in = rand_channel();
        px.green_in = rand_channel();
        px.blue_in = rand_channel();
        return px;
    endfunction

    function automatic int unsigned idle_rate_pick();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 3;
            2: return 8;
            default: return 20;
        endcase
    endfunction

    task automatic send_pixel(input ifnb_pkg::t_in_item px);
        if (in_idle_rate != 0 && $urandom_range(1, in_idle_rate) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= px;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        emit_expected_pixels(px);
        pix_sent++;
    endtask

    task automatic send_n(input int unsigned n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    task automatic finish_frame();
        do send_pixel(rand_pixel()); while (col_pos != 0 || row_pos != 0);
    endtask

    // no result pending and the pipeline given time to settle
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx,
                             input logic [CFG_DW-1:0] data, input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            ifnb_pkg::CFG_FRAME_WIDTH:  reg_width = data[9:0];
            ifnb_pkg::CFG_FRAME_HEIGHT: reg_height = data;
            ifnb_pkg::CFG_FIRST_ROW:    reg_first = data;
            default: ;
        endcase
        if (!more) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                             input logic [CFG_DW-1:0] fr);
        wait_for_drain();
        write_reg(ifnb_pkg::CFG_FRAME_WIDTH, w, 1'b1);
        write_reg(ifnb_pkg::CFG_FRAME_HEIGHT, h, 1'b1);
        write_reg(ifnb_pkg::CFG_FIRST_ROW, fr, 1'b0);
        settings_used++;
    endtask

    // widening is only allowed in row 0, where the row store is still being filled
    task automatic retune_mid_frame();
        wait_for_drain();
        case ($urandom_range(0, 2))
            0: write_reg(ifnb_pkg::CFG_FRAME_WIDTH,
                         CFG_DW'((row_pos == 0) ? $urandom_range(0, 24)
                                                : $urandom_range(0, eff_width())), 1'b0);
            1: write_reg(ifnb_pkg::CFG_FRAME_HEIGHT, CFG_DW'($urandom_range(0, 10)), 1'b0);
            default: write_reg(ifnb_pkg::CFG_FIRST_ROW, CFG_DW'($urandom_range(0, 12)), 1'b0);
        endcase
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        ifnb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            res_seen++;
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result at column %0d row %0d",
                       o_out_data.column, o_out_data.row_index);
                err_cnt++;
            end else begin
                want = awaited_pixels.pop_front();
                compare_field("column", 16'(want.column), 16'(o_out_data.column));
                compare_field("row_index", 16'(want.row_index), 16'(o_out_data.row_index));
                compare_field("red_out", 16'(want.red_out), 16'(o_out_data.red_out));
                compare_field("green_out", 16'(want.green_out), 16'(o_out_data.green_out));
                compare_field("blue_out", 16'(want.blue_out), 16'(o_out_data.blue_out));
                compare_field("last_of_run", 16'(want.last_of_run),
                              16'(o_out_data.last_of_run));
            end
        end
    end

    initial begin : sink_side
        forever begin
            @(posedge i_clk);
            if (out_idle_rate != 0 && $urandom_range(1, out_idle_rate) == 1) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // reset registers, then narrow the row and shrink the frame part way through
    task automatic test_midframe_from_reset();
        send_n(3);
        wait_for_drain();
        write_reg(ifnb_pkg::CFG_FRAME_WIDTH, 12'd2, 1'b0);
        // column 3 now lies past the row end, then rows 1 and 2
        send_n(5);
        wait_for_drain();
        // height and first row both below their minimum
        write_reg(ifnb_pkg::CFG_FRAME_HEIGHT, 12'd0, 1'b1);
        write_reg(ifnb_pkg::CFG_FIRST_ROW, 12'd0, 1'b0);
        // row 3 is beyond the new height and wraps
        send_n(2);
        finish_frame();
    endtask

    task automatic test_channel_extremes();
        logic [7:0] ext [6] = '{8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80};
        ifnb_pkg::t_in_item px;
        configure(12'd3, 12'd4, 12'd1);
        for (int k = 0; k < 12; k++) begin
            px.red_in = ext[k % 6];
            px.green_in = ext[(k + 1) % 6];
            px.blue_in = ext[(k + 3) % 6];
            send_pixel(px);
        end
    endtask

    task automatic test_register_extremes();
        in_idle_rate = 20;
        out_idle_rate = 20;
        // widest row: width clamps to the store depth, then narrow once row 1 has begun
        configure(12'h3FF, 12'd3, 12'd1);
        send_n(MAX_W + 2);
        wait_for_drain();
        write_reg(ifnb_pkg::CFG_FRAME_WIDTH, 12'd2, 1'b0);
        finish_frame();
        // narrowest and tallest frame, then cut the height back a few rows down
        configure(12'h000, 12'hFFF, 12'd4093);
        send_n(6);
        wait_for_drain();
        write_reg(ifnb_pkg::CFG_FRAME_HEIGHT, 12'd4, 1'b0);
        finish_frame();
        wait_for_drain();
        write_reg(CFG_UNUSED, 12'hFFF, 1'b0);
        // top data bits ignored for width, first row past the end blurs nothing
        configure(12'hC07, 12'd4, 12'hFFF);
        finish_frame();
    endtask

    task automatic test_random_frames(input int unsigned quota, input bit calm);
        int unsigned start, h_raw;
        start = pix_sent;
        while (pix_sent - start < quota) begin
            in_idle_rate = calm ? 0 : idle_rate_pick();
            out_idle_rate = calm ? 0 : idle_rate_pick();
            h_raw = $urandom_range(0, 9);
            configure(CFG_DW'($urandom_range(0, 24)), CFG_DW'(h_raw),
                      CFG_DW'($urandom_range(0, h_raw + 1)));
            if (!calm && $urandom_range(0, 3) == 0) begin
                send_n($urandom_range(1, eff_width() * eff_height() - 1));
                retune_mid_frame();
            end
            finish_frame();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_midframe_from_reset();
        test_channel_extremes();
        test_register_extremes();
        test_random_frames(170, 1'b0);
        test_random_frames(50, 1'b1);
        wait_for_drain();
        $display("sent %0d pixels, checked %0d results over %0d frame settings",
                 pix_sent, res_seen, settings_used);
        $display("widths 2 to %0d, heights 3 to 4095, mid-frame register changes, stalls",
                 MAX_W);
        if (err_cnt == 0) begin
            $display("inplace_four_neighbour_blur_tb: done, clean");
        end else begin
            $display("inplace_four_neighbour_blur_tb: done, errors");
        end
        $finish;
    end

endmodule
